### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL of the channel effects ticker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CET_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CET_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### sv/cet_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cet_pkg
// Types and constants of the channel effects ticker: transaction payloads,
// command kinds and fade direction codes.
// ---------------------------------------------------------------------------
package cet_pkg;

    // Command kinds carried in the kind field
    typedef enum logic [3:0] {
        KIND_TICK     = 4'd0,
        KIND_PERIOD   = 4'd1,
        KIND_PORTA    = 4'd2,
        KIND_VIBRATO  = 4'd3,
        KIND_ENVELOPE = 4'd4,
        KIND_ADDBEGIN = 4'd5,
        KIND_VOLUME   = 4'd6,
        KIND_RESET    = 4'd7,
        KIND_FADE     = 4'd8,
        KIND_BEGIN    = 4'd9,
        KIND_GATE     = 4'd10
    } kind_t;

    // Master fade direction codes
    localparam logic [1:0] FADE_IDLE = 2'd0;
    localparam logic [1:0] FADE_UP   = 2'd1;
    localparam logic [1:0] FADE_DOWN = 2'd3;

    localparam logic [7:0] MASTER_RESET = 8'h40;

    // Input transaction
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [7:0]  byte_c;
        logic [15:0] word_value;
        logic [23:0] start_address;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [15:0] current_period;
        logic [7:0]  channel_volume;
        logic [7:0]  master_volume;
        logic [9:0]  mixed_volume;
        logic [23:0] sample_address;
    } result_t;

endpackage

`default_nettype wire

### sv/cet_item_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cet_item_if
// Valid/ready channel carrying command and tick transactions.
// ---------------------------------------------------------------------------
interface cet_item_if;
    import cet_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/cet_result_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cet_result_if
// Valid/ready channel carrying result transactions.
// ---------------------------------------------------------------------------
interface cet_result_if;
    import cet_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/channel_effects_ticker.sv
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// channel_effects_ticker
// Per-tick effect unit of one sound channel: address sweep, vibrato,
// portamento, volume envelope and master fade, one result per transaction.
// ---------------------------------------------------------------------------
//  channel  direction  payload   use
//  item     sink       item_t    commands and ticks
//  result   source     result_t  period, volumes and address after the item
//
//  One transaction per cycle while the result is not stalled.
//  Stage 1 is the input register, stage 2 the effect pass and the result
//  register; the rate is set by the single effect pass per transaction.
//  A stalled result holds stage 2, and stage 1 keeps one transaction behind it.
//  Reset clears all effect state, the master level resets to 0x40.
// ---------------------------------------------------------------------------
module channel_effects_ticker #(
    parameter int ADDRESS_BITS = 24
) (
    input  wire            clk,
    input  wire            rst_n,
    cet_item_if.sink       item,
    cet_result_if.source   result
);
    import cet_pkg::*;

    typedef struct packed {
        logic [7:0]  effects_gate;
        logic [15:0] sweep_delta;
        logic [7:0]  sweep_time;
        logic [7:0]  sweep_reload;
        logic [15:0] vibrato_offset;
        logic [7:0]  vibrato_width;
        logic [7:0]  vibrato_time;
        logic [7:0]  vibrato_reload;
        logic [15:0] target_period;
        logic [15:0] period_now;
        logic [15:0] glide_period;
        logic [15:0] glide_rate;
        logic [7:0]  glide_time;
        logic [7:0]  glide_reload;
        logic [7:0]  volume_now;
        logic [7:0]  envelope_rate;
        logic [7:0]  envelope_time;
        logic [7:0]  envelope_reload;
        logic [7:0]  envelope_end;
        logic [7:0]  master_level;
        logic [1:0]  fade_step;
        logic [7:0]  fade_time;
        logic [7:0]  fade_reload;
        logic [7:0]  fade_target;
    } fx_state_t;

    // Input and result stage
    logic        in_valid_reg;
    item_t       in_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        advance;

    // Effect state
    fx_state_t               st_reg, st_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;

    // Datapath intermediates
    logic [15:0]        vib_off_new;
    logic signed [16:0] vib_factor;
    logic signed [33:0] vib_prod;
    logic [15:0]        vib_period;
    logic               glide_down;
    logic signed [17:0] glide_factor;
    logic signed [34:0] glide_prod;
    logic signed [35:0] glide_sum;
    logic signed [27:0] glide_a;
    logic signed [27:0] target_wide;
    logic               glide_stop;
    logic [15:0]        mix_prod;
    logic [31:0]        start_wide;
    logic [31:0]        addr_wide;
    logic [7:0]         env_rl;

    // Handshake: stage 2 moves when the result slot is free or being taken
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready   = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_reg <= item.data;
        end
    end

    // Vibrato: new offset scales the target period, floor of /2048
    assign vib_off_new = st_reg.vibrato_offset + 16'($signed(st_reg.vibrato_width));
    assign vib_factor  = 17'sh800 + 17'($signed(vib_off_new));
    assign vib_prod    = $signed({1'b0, st_reg.target_period}) * vib_factor;
    assign vib_period  = vib_prod[26:11];

    // Portamento: one multiplier, factor and bias chosen by glide direction
    assign glide_down   = st_reg.glide_period > st_reg.target_period;
    assign glide_factor = glide_down ? (18'sd256 - $signed({2'b00, st_reg.glide_rate}))
                                     : (18'sd256 + $signed({2'b00, st_reg.glide_rate}));
    assign glide_prod   = $signed({1'b0, st_reg.glide_period}) * glide_factor;
    assign glide_sum    = 36'(glide_prod) - (glide_down ? 36'sd128 : 36'sd0);
    assign glide_a      = glide_sum[35:8];
    assign target_wide  = $signed({12'd0, st_reg.target_period});
    assign glide_stop   = (st_reg.glide_period == st_reg.target_period) ||
                          (glide_down ? (glide_a <= target_wide) : (glide_a >= target_wide));

    assign start_wide = 32'(in_reg.start_address);

    // Effect pass and command decode
    always_comb
    begin
        st_next   = st_reg;
        addr_next = addr_reg;
        env_rl    = st_reg.envelope_reload;

        unique case (kind_t'(in_reg.kind))
            KIND_TICK:
            begin
                if (!st_reg.effects_gate[7])
                begin
                    if (st_reg.effects_gate == 8'd0)
                    begin
                        st_next.effects_gate = 8'd1;
                    end
                    else
                    begin
                        // ping-pong address sweep
                        if (st_reg.sweep_time != 8'd0)
                        begin
                            addr_next = addr_reg + ADDRESS_BITS'($signed(st_reg.sweep_delta));
                            st_next.sweep_time = st_reg.sweep_time - 8'd1;
                            if (st_next.sweep_time == 8'd0)
                            begin
                                st_next.sweep_delta = 16'd0 - st_reg.sweep_delta;
                                st_next.sweep_time  = st_reg.sweep_reload;
                            end
                        end

                        // vibrato
                        if (st_reg.vibrato_reload != 8'd0)
                        begin
                            st_next.vibrato_offset = vib_off_new;
                            if (st_reg.glide_rate == 16'd0)
                            begin
                                st_next.period_now = vib_period;
                            end
                            st_next.vibrato_time = st_reg.vibrato_time - 8'd1;
                            if (st_next.vibrato_time == 8'd0)
                            begin
                                st_next.vibrato_time  = st_reg.vibrato_reload;
                                st_next.vibrato_width = 8'd0 - st_reg.vibrato_width;
                            end
                        end

                        // portamento
                        if (st_reg.glide_rate != 16'd0)
                        begin
                            st_next.glide_time = st_reg.glide_time - 8'd1;
                            if (st_next.glide_time == 8'd0)
                            begin
                                st_next.glide_time = st_reg.glide_reload;
                                if (glide_stop)
                                begin
                                    st_next.glide_rate   = 16'd0;
                                    st_next.glide_period = st_reg.target_period;
                                    st_next.period_now   = st_reg.target_period;
                                end
                                else
                                begin
                                    st_next.glide_period = glide_a[15:0];
                                    st_next.period_now   = glide_a[15:0];
                                end
                            end
                        end

                        // volume envelope
                        if (st_reg.envelope_reload != 8'd0)
                        begin
                            st_next.envelope_time = st_reg.envelope_time - 8'd1;
                            if (st_reg.envelope_time == 8'd0)
                            begin
                                st_next.envelope_time = st_reg.envelope_reload;
                                if (st_reg.volume_now > st_reg.envelope_end)
                                begin
                                    if (st_reg.volume_now < st_reg.envelope_rate)
                                    begin
                                        env_rl = 8'd0;
                                    end
                                    else
                                    begin
                                        st_next.volume_now = st_reg.volume_now -
                                                             st_reg.envelope_rate;
                                    end
                                    if (st_reg.envelope_end > st_next.volume_now)
                                    begin
                                        env_rl = 8'd0;
                                    end
                                end
                                else if (st_reg.volume_now < st_reg.envelope_end)
                                begin
                                    st_next.volume_now = st_reg.volume_now +
                                                         st_reg.envelope_rate;
                                    if (st_reg.envelope_end < st_next.volume_now)
                                    begin
                                        env_rl = 8'd0;
                                    end
                                end
                                st_next.envelope_reload = env_rl;
                                if (env_rl == 8'd0)
                                begin
                                    st_next.envelope_time = 8'd0;
                                    st_next.volume_now    = st_reg.envelope_end;
                                end
                            end
                        end

                        // master fade
                        if (st_reg.fade_step != FADE_IDLE)
                        begin
                            st_next.fade_time = st_reg.fade_time - 8'd1;
                            if (st_next.fade_time == 8'd0)
                            begin
                                st_next.fade_time = st_reg.fade_reload;
                                st_next.master_level = (st_reg.fade_step == FADE_UP) ?
                                                       st_reg.master_level + 8'd1 :
                                                       st_reg.master_level - 8'd1;
                                if (st_reg.fade_target == st_next.master_level)
                                begin
                                    st_next.fade_step = FADE_IDLE;
                                end
                            end
                        end
                    end
                end
            end
            KIND_PERIOD:
            begin
                st_next.target_period = in_reg.word_value;
                if (st_reg.glide_rate == 16'd0)
                begin
                    st_next.period_now = in_reg.word_value;
                end
            end
            KIND_PORTA:
            begin
                st_next.glide_reload = in_reg.byte_a;
                st_next.glide_time   = 8'd1;
                if (st_reg.glide_rate == 16'd0)
                begin
                    st_next.glide_period = st_reg.target_period;
                end
                st_next.glide_rate = in_reg.word_value;
            end
            KIND_VIBRATO:
            begin
                st_next.vibrato_reload = in_reg.byte_a;
                st_next.vibrato_time   = {1'b0, in_reg.byte_a[7:1]};
                st_next.vibrato_width  = in_reg.byte_c;
                if (st_reg.glide_rate == 16'd0)
                begin
                    st_next.period_now     = st_reg.target_period;
                    st_next.vibrato_offset = 16'd0;
                end
            end
            KIND_ENVELOPE:
            begin
                st_next.envelope_reload = in_reg.byte_b;
                st_next.envelope_time   = in_reg.byte_b;
                st_next.envelope_end    = in_reg.byte_c;
                st_next.envelope_rate   = in_reg.byte_a;
            end
            KIND_ADDBEGIN:
            begin
                st_next.sweep_time   = in_reg.byte_a;
                st_next.sweep_reload = in_reg.byte_a;
                st_next.sweep_delta  = in_reg.word_value;
                addr_next = addr_reg + ADDRESS_BITS'($signed(in_reg.word_value));
            end
            KIND_VOLUME:
            begin
                st_next.volume_now = in_reg.byte_c;
            end
            KIND_RESET:
            begin
                st_next.envelope_reload = 8'd0;
                st_next.vibrato_reload  = 8'd0;
                st_next.glide_rate      = 16'd0;
                st_next.sweep_time      = 8'd0;
            end
            KIND_FADE:
            begin
                st_next.fade_target = in_reg.byte_c;
                st_next.fade_time   = in_reg.byte_a;
                st_next.fade_reload = in_reg.byte_a;
                if ((in_reg.byte_a == 8'd0) || (st_reg.master_level == in_reg.byte_c))
                begin
                    st_next.master_level = in_reg.byte_c;
                    st_next.fade_step    = FADE_IDLE;
                end
                else
                begin
                    st_next.fade_step = (st_reg.master_level > in_reg.byte_c) ?
                                        FADE_DOWN : FADE_UP;
                end
            end
            KIND_BEGIN:
            begin
                st_next.sweep_time = 8'd0;
                addr_next = start_wide[ADDRESS_BITS-1:0];
            end
            KIND_GATE:
            begin
                st_next.effects_gate = in_reg.byte_c;
            end
            default:
            begin
                // unused kinds only report
            end
        endcase
    end

    // Mixed volume and address view of the updated state
    assign mix_prod  = st_next.volume_now * st_next.master_level;
    assign addr_wide = 32'(addr_next);

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '{master_level: MASTER_RESET, default: '0};
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg        <= st_next;
                addr_reg      <= addr_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.current_period <= st_next.period_now;
            out_reg.channel_volume <= st_next.volume_now;
            out_reg.master_volume  <= st_next.master_level;
            out_reg.mixed_volume   <= mix_prod[15:6];
            out_reg.sample_address <= addr_wide[23:0];
        end
    end

    // Checks
    `CET_ASSERT_IMP(a_fade_code, clk, rst_n, 1'b1, st_reg.fade_step != 2'd2,
        "fade step holds an unused code")
    `CET_ASSERT_NXT(a_adv_result, clk, rst_n, advance, out_valid_reg,
        "processed transaction produced no result")
    `CET_ASSERT_NXT(a_gate_hold, clk, rst_n,
        advance && (in_reg.kind == KIND_TICK) && st_reg.effects_gate[7],
        (addr_reg == $past(addr_reg)) && (st_reg == $past(st_reg)),
        "tick changed state while effects gated off")
    `CET_ASSERT_NXT(a_reset_cmd, clk, rst_n, advance && (in_reg.kind == KIND_RESET),
        (st_reg.glide_rate == 16'd0) && (st_reg.envelope_reload == 8'd0),
        "reset command left an effect running")
    `CET_ASSERT_IMP(a_stall, clk, rst_n, !item.ready,
        in_valid_reg && out_valid_reg && !result.ready,
        "input stalled without a held result")

endmodule

`default_nettype wire
